/* rtl/core/cfc_pkg.sv */
// cfc_pkg: types, codes and constants shared by the command frame checker.
// Used by cfc_front, cfc_back, cfc_fifo users and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfc_pkg;

   localparam int unsigned CSR_WIDTH = 16;
   localparam int unsigned CMD_DEPTH_DEFAULT = 4;
   localparam int unsigned RSP_DEPTH_DEFAULT = 2;

   localparam logic [3:0] FRAME_LAST = 4'd11;
   localparam logic [3:0] CRC_LEN = 4'd10;
   localparam logic [3:0] NO_FRAME = 4'd12;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] HEADER_0 = 8'hAA;
   localparam logic [7:0] HEADER_1 = 8'h55;

   localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd250;
   localparam logic [15:0] TELEMETRY_PERIOD_RESET = 16'd20;
   localparam logic [15:0] TELEMETRY_RESYNC_RESET = 16'd100;
   localparam logic [15:0] POLL_PERIOD_RESET = 16'd1000;
   localparam logic [15:0] AGE_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_LINK_TIMEOUT = 2'd0,
      CSR_TELEMETRY_PERIOD = 2'd1,
      CSR_TELEMETRY_RESYNC = 2'd2,
      CSR_POLL_PERIOD = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FS_NONE = 3'd0,
      FS_ACCEPTED = 3'd1,
      FS_NOT_READY = 3'd2,
      FS_BAD_HEADER = 3'd3,
      FS_BAD_CRC = 3'd4
   } frame_status_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic op;
      logic [7:0] data_byte;
      logic first_byte;
      logic drive_ready;
   } req_type;

   typedef struct packed {
      frame_status_type frame_status;
      logic [31:0] linear_speed_bits;
      logic [31:0] turn_rate_bits;
      logic stop_request;
      logic telemetry_request;
      logic voltage_poll_request;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic is_tick;
      logic drive_ready;
      frame_status_type frame_status;
      logic [31:0] linear_speed_bits;
      logic [31:0] turn_rate_bits;
   } cmd_type;

endpackage
`default_nettype wire

/* rtl/core/cfc_fifo.sv */
// cfc_fifo: small register queue with count, used between front and back
// and on the result side. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module cfc_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire logic [WIDTH-1:0] push_data,
   output logic full,
   input wire logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/cfc_front.sv */
// cfc_front: frame parser. Tracks byte position, crc and header per byte item
// and classifies each accepted item into a cmd_type. Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfc_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire cfc_pkg::req_type req_data,
   output cfc_pkg::cmd_type cmd_data
);
   logic [3:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic header_good_ff, header_good_in;
   logic [63:0] payload_ff, payload_in;
   logic [7:0] low_csum_ff, low_csum_in;

   logic [3:0] pos0;
   logic [15:0] crc0;
   logic hg0;
   logic [63:0] pw0;
   logic [7:0] lcb0;
   logic [2:0] slot;
   logic [15:0] rx_crc;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ cfc_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   always_comb begin
      // a first byte restarts the frame, dropping any partial one
      if (req_data.first_byte) begin
         pos0 = '0;
         crc0 = cfc_pkg::CRC_INIT;
         hg0 = 1'b1;
         pw0 = '0;
         lcb0 = '0;
      end else begin
         pos0 = pos_ff;
         crc0 = crc_ff;
         hg0 = header_good_ff;
         pw0 = payload_ff;
         lcb0 = low_csum_ff;
      end
      slot = 3'(pos0 - 4'd2);
      rx_crc = {req_data.data_byte, lcb0};

      pos_in = pos_ff;
      crc_in = crc_ff;
      header_good_in = header_good_ff;
      payload_in = payload_ff;
      low_csum_in = low_csum_ff;

      cmd_data.is_tick = req_data.op;
      cmd_data.drive_ready = req_data.drive_ready;
      cmd_data.frame_status = cfc_pkg::FS_NONE;
      cmd_data.linear_speed_bits = '0;
      cmd_data.turn_rate_bits = '0;

      if (req_data.op == cfc_pkg::OP_BYTE) begin
         pos_in = pos0;
         crc_in = crc0;
         header_good_in = hg0;
         payload_in = pw0;
         low_csum_in = lcb0;
         if (pos0 < cfc_pkg::NO_FRAME) begin
            pos_in = pos0 + 4'd1;
            if (pos0 < cfc_pkg::CRC_LEN) begin
               crc_in = crc_byte(crc0, req_data.data_byte);
            end
            if (pos0 == 4'd0) begin
               header_good_in = hg0 & (req_data.data_byte == cfc_pkg::HEADER_0);
            end else if (pos0 == 4'd1) begin
               header_good_in = hg0 & (req_data.data_byte == cfc_pkg::HEADER_1);
            end else if (pos0 < cfc_pkg::CRC_LEN) begin
               payload_in[{slot, 3'b000} +: 8] = req_data.data_byte;
            end else if (pos0 == cfc_pkg::CRC_LEN) begin
               low_csum_in = req_data.data_byte;
            end else begin
               // last byte: verdict, header fault wins over crc fault
               pos_in = cfc_pkg::NO_FRAME;
               if (!hg0) begin
                  cmd_data.frame_status = cfc_pkg::FS_BAD_HEADER;
               end else if (rx_crc != crc0) begin
                  cmd_data.frame_status = cfc_pkg::FS_BAD_CRC;
               end else begin
                  cmd_data.frame_status = req_data.drive_ready ?
                     cfc_pkg::FS_ACCEPTED : cfc_pkg::FS_NOT_READY;
                  cmd_data.linear_speed_bits = pw0[31:0];
                  cmd_data.turn_rate_bits = pw0[63:32];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= cfc_pkg::NO_FRAME;
         crc_ff <= cfc_pkg::CRC_INIT;
         header_good_ff <= 1'b0;
         payload_ff <= '0;
         low_csum_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         header_good_ff <= header_good_in;
         payload_ff <= payload_in;
         low_csum_ff <= low_csum_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/cfc_back.sv */
// cfc_back: executes classified items: link watchdog, telemetry schedule,
// voltage poll schedule and configuration registers. Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfc_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire cfc_pkg::csr_index_type csr_index,
   input wire logic [cfc_pkg::CSR_WIDTH-1:0] csr_wdata,
   input wire cfc_pkg::cmd_type cmd_data,
   input wire logic cmd_empty,
   output logic cmd_pop,
   input wire logic rsp_full,
   output logic rsp_push,
   output cfc_pkg::rsp_type rsp_data
);
   logic [15:0] link_timeout_ff, telemetry_period_ff, telemetry_resync_ff, poll_period_ff;
   logic [15:0] link_age_ff, link_age_in;
   logic [15:0] telem_age_ff, telem_age_in;
   logic [15:0] poll_age_ff, poll_age_in;
   logic [15:0] link_up, telem_up, poll_up, telem_rest;

   function automatic logic [15:0] age_up(input logic [15:0] a);
      return (a == cfc_pkg::AGE_MAX) ? a : a + 16'd1;
   endfunction

   assign cmd_pop = ~cmd_empty & ~rsp_full;
   assign rsp_push = cmd_pop;

   always_comb begin
      link_up = age_up(link_age_ff);
      telem_up = age_up(telem_age_ff);
      poll_up = age_up(poll_age_ff);
      telem_rest = telem_up - telemetry_period_ff;

      link_age_in = link_age_ff;
      telem_age_in = telem_age_ff;
      poll_age_in = poll_age_ff;

      rsp_data.frame_status = cmd_data.frame_status;
      rsp_data.linear_speed_bits = cmd_data.linear_speed_bits;
      rsp_data.turn_rate_bits = cmd_data.turn_rate_bits;
      rsp_data.stop_request = 1'b0;
      rsp_data.telemetry_request = 1'b0;
      rsp_data.voltage_poll_request = 1'b0;

      if (cmd_data.is_tick) begin
         link_age_in = link_up;
         rsp_data.stop_request = (link_up > link_timeout_ff);
         telem_age_in = telem_up;
         if (telem_up >= telemetry_period_ff) begin
            // drift correction, snapping to now when lag is too large
            telem_age_in = (telem_rest > telemetry_resync_ff) ? '0 : telem_rest;
            rsp_data.telemetry_request = 1'b1;
         end
         poll_age_in = poll_up;
         if (poll_up >= poll_period_ff) begin
            poll_age_in = '0;
            rsp_data.voltage_poll_request = cmd_data.drive_ready;
         end
      end else if (cmd_data.frame_status == cfc_pkg::FS_ACCEPTED ||
                   cmd_data.frame_status == cfc_pkg::FS_NOT_READY) begin
         link_age_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_age_ff <= '0;
         telem_age_ff <= '0;
         poll_age_ff <= '0;
      end else if (cmd_pop) begin
         link_age_ff <= link_age_in;
         telem_age_ff <= telem_age_in;
         poll_age_ff <= poll_age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_timeout_ff <= cfc_pkg::LINK_TIMEOUT_RESET;
         telemetry_period_ff <= cfc_pkg::TELEMETRY_PERIOD_RESET;
         telemetry_resync_ff <= cfc_pkg::TELEMETRY_RESYNC_RESET;
         poll_period_ff <= cfc_pkg::POLL_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cfc_pkg::CSR_LINK_TIMEOUT: link_timeout_ff <= csr_wdata;
            cfc_pkg::CSR_TELEMETRY_PERIOD: telemetry_period_ff <= csr_wdata;
            cfc_pkg::CSR_TELEMETRY_RESYNC: telemetry_resync_ff <= csr_wdata;
            cfc_pkg::CSR_POLL_PERIOD: poll_period_ff <= csr_wdata;
            default: link_timeout_ff <= link_timeout_ff;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/command_frame_checker_with_link_watchdog.sv */
// Command frame checker with link watchdog.
// Input queue side: req_push / req_full with req_data carrying op, data_byte,
// first_byte and drive_ready; an item is taken when req_push is high and
// req_full low. Each item is a frame byte or a one millisecond tick.
// Result queue side: rsp_empty / rsp_pop; the oldest result sits on rsp_data
// while rsp_empty is low and leaves when rsp_pop is high. Every item gives
// exactly one result, in order.
// Frames are 12 bytes: header AA 55, two little-endian speed words and a
// little-endian CRC-16/MODBUS; the verdict comes with the last byte.
// Ticks age the link watchdog and raise stop, telemetry and poll requests.
// A result passes through the item queue and then the result queue before it
// shows on rsp_data. One item per cycle is sustained while the result queue
// is not full; the front parser classifies an item in its accepting cycle, the
// back scheduler works on the head of the CMD_DEPTH item queue between them.
// If rsp_pop stays low the result queue (RSP_DEPTH) and then the item queue
// fill, and req_full rises; nothing is dropped.
// Reset (synchronous, active high) closes any open frame, clears all ages and
// both queues and loads the register reset values. csr_we writes register
// csr_index with csr_wdata; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module command_frame_checker_with_link_watchdog #(
   parameter int unsigned CMD_DEPTH = cfc_pkg::CMD_DEPTH_DEFAULT,
   parameter int unsigned RSP_DEPTH = cfc_pkg::RSP_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   input wire cfc_pkg::req_type req_data,
   output logic req_full,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output cfc_pkg::rsp_type rsp_data,
   input wire logic csr_we,
   input wire cfc_pkg::csr_index_type csr_index,
   input wire logic [cfc_pkg::CSR_WIDTH-1:0] csr_wdata
);
   localparam int unsigned CMD_W = $bits(cfc_pkg::cmd_type);
   localparam int unsigned RSP_W = $bits(cfc_pkg::rsp_type);

   logic req_accept;
   cfc_pkg::cmd_type front_cmd, back_cmd;
   logic [CMD_W-1:0] cmd_head;
   logic cmd_empty, cmd_pop;
   logic rsp_full, rsp_push;
   cfc_pkg::rsp_type back_rsp;
   logic [RSP_W-1:0] rsp_head;

   assign req_accept = req_push & ~req_full;

   cfc_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(req_accept),
      .req_data(req_data),
      .cmd_data(front_cmd)
   );

   cfc_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .push_data(CMD_W'(front_cmd)),
      .full(req_full),
      .pop(cmd_pop),
      .pop_data(cmd_head),
      .empty(cmd_empty)
   );

   assign back_cmd = cfc_pkg::cmd_type'(cmd_head);

   cfc_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd_data(back_cmd),
      .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop),
      .rsp_full(rsp_full),
      .rsp_push(rsp_push),
      .rsp_data(back_rsp)
   );

   cfc_fifo #(.WIDTH(RSP_W), .DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .push_data(RSP_W'(back_rsp)),
      .full(rsp_full),
      .pop(rsp_pop),
      .pop_data(rsp_head),
      .empty(rsp_empty)
   );

   assign rsp_data = cfc_pkg::rsp_type'(rsp_head);

   // a tick result never carries a frame verdict
   a_tick_no_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.stop_request || rsp_data.telemetry_request ||
       rsp_data.voltage_poll_request)) |-> (rsp_data.frame_status == cfc_pkg::FS_NONE))
      else $error("tick result carries frame status");

   // speed words only come with a frame that passed its header and crc checks
   a_words_need_accept: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.linear_speed_bits != '0 || rsp_data.turn_rate_bits != '0))
      |-> (rsp_data.frame_status == cfc_pkg::FS_ACCEPTED ||
           rsp_data.frame_status == cfc_pkg::FS_NOT_READY))
      else $error("speed words without accepted frame");

   // an accepted item lands in the item queue
   a_item_queued: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd_empty) |=> !cmd_empty)
      else $error("accepted item lost");

   // back never moves an item into a full result queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!rsp_full && rsp_push))
      else $error("result pushed into full queue");
endmodule
`default_nettype wire
